FILE: rtl/core/frame_deframer_crc32_check_macros.svh
// Assertion macros used by the frame deframer top level.
`ifndef FRAME_DEFRAMER_CRC32_CHECK_MACROS_SVH
`define FRAME_DEFRAMER_CRC32_CHECK_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define FDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence on the next clock edge.
`define FDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fdc_pkg.sv
// Types, constants and CRC functions of the frame deframer.
package fdc_pkg;

  localparam logic [7:0]  SYNC0       = 8'hE0;
  localparam logic [7:0]  SYNC1       = 8'h55;
  localparam logic [7:0]  SYNC2       = 8'hAA;
  localparam logic [31:0] CRC_POLY    = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [7:0]  MAX_LEN_RST = 8'd127;
  localparam int unsigned OUT_DATA_W  = 24;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_GOT0 = 3'd1,
    PH_GOT1 = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CRC  = 3'd5
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic       good;
    logic [7:0] length;
    logic       last;
  } result_t;

  // Eight MSB-first shift steps of the CRC register.
  function automatic logic [31:0] crc_shift8(input logic [31:0] crc);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Folds one zero-extended byte into the CRC as a full 32-bit word.
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    c = crc_shift8(c);
    c = crc_shift8(c);
    c = crc_shift8(c);
    c = crc_shift8(c);
    return c;
  endfunction

  localparam logic [31:0] CRC_START = crc_word(CRC_INIT, SYNC0);

endpackage

FILE: rtl/core/frame_deframer_crc32_check.sv
// Top level of the frame deframer with CRC-32 check.
// The block takes one received byte per transaction and hunts for frames of the form
// E0 55 AA, a length byte, that many payload bytes and a big-endian CRC-32
// (polynomial 04C11DB7, initial value all ones, each byte folded in as a zero-extended
// 32-bit word). Every payload byte leaves as a result of kind 0; the fourth CRC byte
// produces one status result of kind 1 with tlast set, the good flag and the length.
// Lengths above the configured maximum drop the frame silently. One byte is taken in every
// cycle: the frame state and CRC register update in the cycle the byte is accepted, and
// the result lands in an output register, so s_axis_tready falls only while that
// register holds a result that the sink does not take.
module frame_deframer_crc32_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0 up: rx_byte.
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0 up: payload_byte[7:0], frame_good[8], frame_length[16:9], zero fill.
  output logic [fdc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0 up: result_kind.
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import fdc_pkg::*;
  `include "frame_deframer_crc32_check_macros.svh"

  phase_e      phase_q, phase_d;
  logic [7:0]  max_len_q;
  logic [7:0]  len_q, len_d;
  logic [7:0]  rem_q, rem_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rx_q, rx_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] crc_next;
  logic [31:0] rx_shift;
  logic [7:0]  b;
  logic        in_fire;
  logic        res_valid;
  logic        res_ready;
  result_t     res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = res_ready;
  assign in_fire       = s_axis_tvalid && res_ready;
  assign b             = s_axis_tdata;
  assign crc_next      = crc_word(crc_q, b);
  assign rx_shift      = {rx_q[23:0], b};

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    rem_d     = rem_q;
    crc_d     = crc_q;
    rx_d      = rx_q;
    idx_d     = idx_q;
    res_valid = 1'b0;
    res       = '0;
    if (in_fire) begin
      case (phase_q)
        PH_GOT0: begin
          if (b == SYNC1) begin
            crc_d   = crc_next;
            phase_d = PH_GOT1;
          end else if (b == SYNC0) begin
            crc_d = CRC_START; rx_d = '0; idx_d = '0; len_d = '0; rem_d = '0;
            phase_d = PH_GOT0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_GOT1: begin
          if (b == SYNC2) begin
            crc_d   = crc_next;
            phase_d = PH_LEN;
          end else if (b == SYNC0) begin
            crc_d = CRC_START; rx_d = '0; idx_d = '0; len_d = '0; rem_d = '0;
            phase_d = PH_GOT0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          if (b > max_len_q) begin
            if (b == SYNC0) begin
              crc_d = CRC_START; rx_d = '0; idx_d = '0; len_d = '0; rem_d = '0;
              phase_d = PH_GOT0;
            end else begin
              phase_d = PH_HUNT;
            end
          end else begin
            crc_d   = crc_next;
            len_d   = b;
            rem_d   = b;
            idx_d   = '0;
            rx_d    = '0;
            phase_d = (b == 8'd0) ? PH_CRC : PH_DATA;
          end
        end
        PH_DATA: begin
          crc_d = crc_next;
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            phase_d = PH_CRC;
          end
          res_valid   = 1'b1;
          res.payload = b;
        end
        PH_CRC: begin
          rx_d = rx_shift;
          if (idx_q != 2'd3) begin
            idx_d = idx_q + 2'd1;
          end else begin
            idx_d      = '0;
            phase_d    = PH_HUNT;
            res_valid  = 1'b1;
            res.kind   = 1'b1;
            res.good   = (rx_shift == crc_q);
            res.length = len_q;
            res.last   = 1'b1;
          end
        end
        default: begin
          if (b == SYNC0) begin
            crc_d = CRC_START; rx_d = '0; idx_d = '0; len_d = '0; rem_d = '0;
            phase_d = PH_GOT0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      max_len_q <= MAX_LEN_RST;
      len_q     <= '0;
      rem_q     <= '0;
      crc_q     <= CRC_INIT;
      rx_q      <= '0;
      idx_q     <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      crc_q   <= crc_d;
      rx_q    <= rx_d;
      idx_q   <= idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  fdc_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_ready_o   (res_ready),
    .res_i         (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `FDC_ASSERT(a_last_is_status, m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser), "tlast must mark status results only")
  `FDC_ASSERT(a_payload_clean, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[23:8] == 16'd0), "Payload result carries status bits.")
  `FDC_ASSERT(a_data_has_bytes, (phase_q == PH_DATA) |-> (rem_q != 8'd0), "Payload phase with no bytes remaining.")
  `FDC_ASSERT(a_idx_in_crc, (idx_q != 2'd0) |-> (phase_q == PH_CRC), "CRC byte index set outside the CRC phase.")
  `FDC_ASSERT_NEXT(a_status_out, in_fire && (phase_q == PH_CRC) && (idx_q == 2'd3), m_axis_tvalid && m_axis_tuser, "Last CRC byte did not produce a status result.")

endmodule

FILE: rtl/core/fdc_out_reg.sv
// Result register that drives the master stream of the frame deframer.
module fdc_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  output logic                   res_ready_o,
  input  fdc_pkg::result_t       res_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0 up: payload_byte[7:0], frame_good[8], frame_length[16:9], zero fill.
  output logic [fdc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0 up: result_kind.
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);
  import fdc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign res_ready_o = !valid_q || m_axis_tready;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {7'd0, res_q.length, res_q.good, res_q.payload};
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;

endmodule

FILE: tb/sv/frame_deframer_crc32_check_monitor.sv
// Checker that predicts the deframer results from the accepted byte stream and compares them.
module frame_deframer_crc32_check_monitor
  import fdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  rx_valid_i,
  input  logic                  rx_ready_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [OUT_DATA_W-1:0] res_data_i,
  input  logic                  res_kind_i,
  input  logic                  res_last_i,
  output int                    mismatches_o,
  output int                    pending_o
);

  phase_e      phase;
  logic [7:0]  max_len;
  logic [7:0]  frame_len;
  logic [7:0]  left;
  logic [31:0] crc;
  logic [31:0] rx_crc;
  logic [1:0]  crc_idx;
  int          errors;
  result_t     frame_out_q[$];

  function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 32; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic void hunt_from(input logic [7:0] b);
    if (b == SYNC0) begin
      crc       = crc_fold(CRC_INIT, SYNC0);
      rx_crc    = '0;
      crc_idx   = '0;
      frame_len = '0;
      left      = '0;
      phase     = PH_GOT0;
    end else begin
      phase = PH_HUNT;
    end
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (phase)
      PH_GOT0: begin
        if (b == SYNC1) begin
          crc   = crc_fold(crc, b);
          phase = PH_GOT1;
        end else begin
          hunt_from(b);
        end
      end
      PH_GOT1: begin
        if (b == SYNC2) begin
          crc   = crc_fold(crc, b);
          phase = PH_LEN;
        end else begin
          hunt_from(b);
        end
      end
      PH_LEN: begin
        if (b > max_len) begin
          hunt_from(b);
        end else begin
          crc       = crc_fold(crc, b);
          frame_len = b;
          left      = b;
          crc_idx   = '0;
          rx_crc    = '0;
          if (b == 8'd0) begin
            phase = PH_CRC;
          end else begin
            phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        crc  = crc_fold(crc, b);
        left = left - 8'd1;
        if (left == 8'd0) begin
          phase = PH_CRC;
        end
        r.payload = b;
        frame_out_q.push_back(r);
      end
      PH_CRC: begin
        rx_crc = {rx_crc[23:0], b};
        if (crc_idx != 2'd3) begin
          crc_idx = crc_idx + 2'd1;
        end else begin
          crc_idx  = '0;
          phase    = PH_HUNT;
          r.kind   = 1'b1;
          r.good   = (rx_crc == crc);
          r.length = frame_len;
          r.last   = 1'b1;
          frame_out_q.push_back(r);
        end
      end
      default: begin
        hunt_from(b);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      phase        = PH_HUNT;
      max_len      = MAX_LEN_RST;
      frame_len    = '0;
      left         = '0;
      crc          = CRC_INIT;
      rx_crc       = '0;
      crc_idx      = '0;
      errors       = 0;
      frame_out_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        max_len = cfg_data_i;
      end
      if (res_valid_i && res_ready_i) begin
        if (frame_out_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result: kind %0b data %h last %0b",
                     $time, res_kind_i, res_data_i, res_last_i);
          end
        end else begin
          want = frame_out_q.pop_front();
          if (res_kind_i !== want.kind || res_data_i[7:0] !== want.payload ||
              res_data_i[8] !== want.good || res_data_i[16:9] !== want.length ||
              res_last_i !== want.last || res_data_i[OUT_DATA_W-1:17] !== '0) begin
            errors++;
            if (errors <= 10) begin
              $display({"%0t: mismatch: expected kind %0b byte %h good %0b length %0d ",
                        "last %0b, got kind %0b byte %h good %0b length %0d last %0b fill %h"},
                       $time, want.kind, want.payload, want.good, want.length, want.last,
                       res_kind_i, res_data_i[7:0], res_data_i[8], res_data_i[16:9],
                       res_last_i, res_data_i[OUT_DATA_W-1:17]);
            end
          end
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        absorb_byte(rx_byte_i);
      end
      mismatches_o <= errors;
      pending_o    <= frame_out_q.size();
    end
  end

endmodule

FILE: tb/sv/frame_deframer_crc32_check_tb.sv
// Testbench top for the frame deframer: drives byte streams and limit writes, gives the verdict.
module frame_deframer_crc32_check_tb;
  import fdc_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [7:0]            cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  int mismatches;
  int pending;
  int items_sent = 0;
  int max_len_now = MAX_LEN_RST;
  bit src_gaps = 1'b0;
  bit snk_gaps = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  frame_deframer_crc32_check dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  frame_deframer_crc32_check_monitor frame_mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .rx_valid_i   (s_tvalid),
    .rx_ready_i   (s_tready),
    .rx_byte_i    (s_tdata),
    .res_valid_i  (m_tvalid),
    .res_ready_i  (m_tready),
    .res_data_i   (m_tdata),
    .res_kind_i   (m_tuser),
    .res_last_i   (m_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    gap = src_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    if (counted) begin
      items_sent++;
    end
  endtask

  task automatic send_frame(input int len, input bit bad_crc);
    logic [31:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    for (int i = 0; i < len + 4; i++) begin
      case (i)
        0:       b = SYNC0;
        1:       b = SYNC1;
        2:       b = SYNC2;
        3:       b = 8'(len);
        default: b = 8'($urandom);
      endcase
      crc = frame_mon.crc_fold(crc, b);
      send_byte(b, 1'b1);
    end
    if (bad_crc) begin
      crc ^= 32'd1 << $urandom_range(0, 31);
    end
    for (int i = 3; i >= 0; i--) begin
      send_byte(crc[8*i +: 8], 1'b1);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(input int value);
    cfg_valid <= 1'b1;
    cfg_data  <= 8'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    max_len_now = value;
  endtask

  function automatic int pick_len();
    int cap;
    cap = (max_len_now < 12) ? max_len_now : 12;
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(0, max_len_now);
    end
    return $urandom_range(0, cap);
  endfunction

  task automatic run_traffic(input int target);
    int start;
    int pick;
    int n;
    start = items_sent;
    while (items_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_frame(pick_len(), $urandom_range(0, 4) == 0);
      end else if (pick < 80) begin
        send_byte(SYNC0, 1'b1);
        if ($urandom_range(0, 1) == 1) begin
          send_byte(SYNC1, 1'b1);
        end
        send_byte(8'($urandom), 1'b1);
      end else if (pick < 88) begin
        send_byte(SYNC0, 1'b1);
        send_byte(SYNC1, 1'b1);
        send_byte(SYNC2, 1'b1);
        if (max_len_now < 255) begin
          send_byte(8'($urandom_range(max_len_now + 1, 255)), 1'b1);
        end else begin
          send_byte(8'($urandom_range(1, 12)), 1'b1);
        end
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(($urandom_range(0, 3) == 0) ? SYNC0 : 8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    int gap;
    forever begin
      gap = snk_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(SYNC1, 1'b0);
    send_byte(SYNC2, 1'b0);
    send_frame(0, 1'b0);
    send_frame(1, 1'b1);
    send_byte(SYNC0, 1'b1);
    send_byte(8'h12, 1'b1);
    send_byte(SYNC0, 1'b1);
    send_byte(SYNC1, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(SYNC0, 1'b1);
    send_byte(SYNC1, 1'b1);
    send_frame(2, 1'b0);
    send_byte(SYNC0, 1'b1);
    send_frame(1, 1'b0);
    send_byte(SYNC0, 1'b1);
    send_byte(SYNC1, 1'b1);
    send_byte(SYNC2, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(SYNC0, 1'b1);
    send_byte(SYNC1, 1'b1);
    send_byte(SYNC2, 1'b1);
    send_frame(3, 1'b0);
    send_frame(127, 1'b0);

    drain();
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
    write_max_len(0);
    run_traffic(150);

    drain();
    src_gaps = 1'b1;
    snk_gaps = 1'b0;
    write_max_len(255);
    send_frame(255, 1'b0);
    send_frame(224, 1'b1);
    run_traffic(150);

    for (int p = 0; p < 4; p++) begin
      drain();
      src_gaps = 1'($urandom_range(0, 1));
      snk_gaps = 1'($urandom_range(0, 1));
      write_max_len($urandom_range(1, 254));
      run_traffic(150);
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
